@@ hw/rtl/rdac_pkg.sv @@
// package for the ramdac host register interface
// constants and types shared by the top level and the palette memory; no dependencies
`default_nettype none
package rdac_pkg;
  localparam int PaletteEntries = 528;
  localparam int WindowTypeEntries = 16;
  localparam logic [3:0] GrpCursor = 4'h1;
  localparam logic [3:0] GrpControl = 4'h2;
  localparam logic [3:0] GrpWindow = 4'h3;
  localparam logic [7:0] ChipId = 8'h2A;
  localparam logic [7:0] ChipRev = 8'h0A;
  localparam logic [7:0] RevAddr = 8'h20;

  typedef enum logic [1:0] {
    PortAddrLo = 2'd0,
    PortAddrHi = 2'd1,
    PortRegs   = 2'd2,
    PortPal    = 2'd3
  } port_e;

  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StClear = 2'd1,
    StRead  = 2'd2,
    StOut   = 2'd3
  } state_e;

  // address wide enough for the largest palette (4095 entries of 3 bytes)
  typedef struct packed {
    logic       we;
    logic [13:0] addr;
    logic [7:0] wdata;
  } mem_req_t;
endpackage
`default_nettype wire

@@ hw/rtl/rdac_palette_ram.sv @@
// palette byte memory, one write or read port, registered read data
// uses rdac_pkg for the request struct
`default_nettype none
module rdac_palette_ram import rdac_pkg::*; #(
  parameter int Depth = PaletteEntries * 3
) (
  input  wire logic       clk_i,
  input  wire mem_req_t   req_i,
  input  wire logic       en_i,
  output logic [7:0]      rdata_o
);
  localparam int Aw = $clog2(Depth);
  logic [7:0] mem [Depth];
  logic [Aw-1:0] a;
  assign a = req_i.addr[Aw-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (req_i.we) mem[a] <= req_i.wdata;
      rdata_o <= mem[a];
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/ramdac_host_register_interface.sv @@
// top level of the ramdac host register interface
// depends on rdac_pkg and rdac_palette_ram
`default_nettype none
// one host byte access per beat. a beat passes through accept, memory read,
// result load and result handshake, so at most one beat is in flight and
// the next beat is accepted only once the result has been taken. after reset
// the palette memory and the control byte memory are cleared, one byte a
// cycle, over the larger of PALETTE_ENTRIES*3 and 48 addresses, and no beat is
// accepted until that sweep is done. cursor colors and window type words are
// small register files cleared at reset.
module ramdac_host_register_interface import rdac_pkg::*; #(
  parameter int PALETTE_ENTRIES = PaletteEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i, // action[0], port[2:1], write_data[10:3]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o  // read_data[7:0]
);
  localparam int Depth = PALETTE_ENTRIES * 3;
  // sweep covers both the palette and the 48 control bytes
  localparam int SweepLen = (Depth > 48) ? Depth : 48;
  localparam int Cw = $clog2(SweepLen + 1);

  state_e state_q, state_d;
  logic [Cw-1:0] clr_q;
  logic [11:0] ap_q;
  logic [1:0] ti_q;
  logic [7:0] cur_q [12];
  logic [23:0] win_q [WindowTypeEntries];
  logic [23:0] stg_q;
  logic [7:0] res_q;
  logic wr_q, pal_q, palok_q, ctl_rd_q;
  logic [7:0] out_q;
  logic ov_q;

  logic wr;
  logic [1:0] port;
  logic [7:0] val;
  assign wr = s_axis_tdata_i[0];
  assign port = s_axis_tdata_i[2:1];
  assign val = s_axis_tdata_i[10:3];

  logic acc;
  assign s_axis_tready_o = (state_q == StIdle) && !ov_q;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  // palette memory request
  mem_req_t req;
  logic men;
  logic [7:0] prd;
  logic palok;
  logic [23:0] pidx;
  assign palok = {20'd0, ap_q} < 32'(PALETTE_ENTRIES);
  assign pidx = {12'd0, ap_q} * 24'd3 + {22'd0, ti_q};
  always_comb begin
    req = '0;
    men = 1'b0;
    if (state_q == StClear) begin
      if (32'(clr_q) < Depth) begin
        req.we = 1'b1;
        req.addr = 14'(clr_q);
        men = 1'b1;
      end
    end else if (acc && port == PortPal && palok) begin
      req.we = wr;
      req.addr = pidx[13:0];
      req.wdata = val;
      men = 1'b1;
    end
  end

  rdac_palette_ram #(.Depth(Depth)) u_ram (
    .clk_i(clk_i), .req_i(req), .en_i(men), .rdata_o(prd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (32'(clr_q) == SweepLen - 1) state_d = StIdle;
      StIdle:  if (acc) state_d = StRead;
      StRead:  state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
    end
  end

  // register side access, decoded combinationally from pointer and index
  logic [11:0] ap_d;
  logic [1:0] ti_d;
  logic [7:0] res_d;
  logic [7:0] low;
  logic [3:0] r, grp;
  logic [5:0] ci;
  logic [3:0] ki;
  logic stt, sts;
  logic ctl_rd;
  assign low = ap_q[7:0];
  assign r = ap_q[3:0];
  assign grp = ap_q[11:8];
  assign ci = 6'(r) * 6'd3 + ((r == 4'd14 || r == 4'd15) ? 6'(ti_q) : 6'd0);
  assign ki = 4'(low[1:0]) * 4'd3 + 4'(ti_q);

  always_comb begin
    ap_d = ap_q;
    ti_d = ti_q;
    res_d = '0;
    stt = 1'b0;
    sts = 1'b0;
    ctl_rd = 1'b0;
    case (port)
      PortAddrLo: begin
        if (wr) ap_d = {ap_q[11:8], val};
        else res_d = ap_q[7:0];
        ti_d = '0;
      end
      PortAddrHi: begin
        if (wr) ap_d = {val[3:0], ap_q[7:0]};
        else res_d = {4'd0, ap_q[11:8]};
        ti_d = '0;
      end
      PortRegs: begin
        if (grp == GrpCursor) begin
          if (wr ? (low < 8'd4) : (low < 8'd2)) begin
            if (!wr) res_d = cur_q[ki];
            stt = 1'b1;
          end
        end else if (grp == GrpControl) begin
          if (low < 8'h10) begin
            if (r == 4'd0) begin
              res_d = ChipId;
              sts = 1'b1;
            end else if (r == 4'd14 || r == 4'd15) begin
              ctl_rd = 1'b1;
              stt = 1'b1;
            end else begin
              ctl_rd = 1'b1;
              sts = 1'b1;
            end
          end else if (low == RevAddr && !wr) begin
            res_d = ChipRev;
            sts = 1'b1;
          end
        end else if (grp == GrpWindow) begin
          if (low < 8'h10) begin
            case (ti_q)
              2'd0: res_d = win_q[r][7:0];
              2'd1: res_d = stg_q[15:8];
              default: res_d = stg_q[23:16];
            endcase
            stt = 1'b1;
          end
        end
      end
      default: stt = 1'b1;
    endcase
    if (sts) begin
      ti_d = '0;
      ap_d = ap_q + 12'd1;
    end else if (stt) begin
      if (ti_q == 2'd2) begin
        ti_d = '0;
        ap_d = ap_q + 12'd1;
      end else begin
        ti_d = ti_q + 2'd1;
      end
    end
  end

  // control byte memory, read data registered at accept, cleared by the sweep
  logic [7:0] ctl_mem [48];
  logic [7:0] crd_q;
  logic ctl_we;
  assign ctl_we = acc && port == PortRegs && grp == GrpControl && wr &&
                  low < 8'h10 && r != 4'd0;

  always_ff @(posedge clk_i) begin
    if (state_q == StClear) begin
      if (32'(clr_q) < 48) ctl_mem[clr_q[5:0]] <= '0;
    end else if (ctl_we) begin
      ctl_mem[ci] <= val;
    end
    if (acc) crd_q <= ctl_mem[ci];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ap_q <= '0;
      ti_q <= '0;
      stg_q <= '0;
      for (int i = 0; i < 12; i++) cur_q[i] <= '0;
      for (int i = 0; i < WindowTypeEntries; i++) win_q[i] <= '0;
    end else if (acc) begin
      ap_q <= ap_d;
      ti_q <= ti_d;
      if (port == PortRegs) begin
        if (grp == GrpCursor && wr && low < 8'd4) cur_q[ki] <= val;
        if (grp == GrpWindow && low < 8'h10) begin
          if (wr) begin
            case (ti_q)
              2'd0: stg_q <= {16'd0, val};
              2'd1: stg_q <= stg_q | {8'd0, val, 8'd0};
              default: begin
                stg_q <= stg_q | {val, 16'd0};
                win_q[r] <= stg_q | {val, 16'd0};
              end
            endcase
          end else if (ti_q == 2'd0) begin
            stg_q <= win_q[r];
          end
        end
      end
    end
  end

  // result path
  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res_d;
      wr_q <= wr;
      pal_q <= (port == PortPal);
      palok_q <= palok;
      ctl_rd_q <= ctl_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      out_q <= '0;
    end else begin
      if (state_q == StOut) begin
        ov_q <= 1'b1;
        if (wr_q) out_q <= '0;
        else if (pal_q) out_q <= palok_q ? prd : 8'd0;
        else if (ctl_rd_q) out_q <= crd_q;
        else out_q <= res_q;
      end else if (ov_q && m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o = out_q;
endmodule
`default_nettype wire
